/* sv/sha256_pkg.sv */
// Shared types and constants of the SHA-256 digest engine.
`default_nettype none

package sha256_pkg;

  typedef logic [31:0] word_t;
  typedef logic [7:0][31:0] word8_t;

  // Control from the sequencer to the message schedule and the round unit.
  typedef struct packed {
    logic       push_byte;
    logic [7:0] byte_val;
    logic       load;
    logic       step;
    logic [5:0] rnd;
  } sha256_ctl_t;

  localparam word8_t H_INIT = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

`default_nettype wire

/* sv/sha256_message_digest.sv */
// Top level of the streaming SHA-256 engine: sequencer, chaining words and output port.
//
//   channel  | direction | tdata            | tuser           | tlast
//   s_axis   | in        | [7:0] data_byte  | [0] has_byte    | end_of_message
//   m_axis   | out       | [31:0] digest    | [2:0] word_index| last_word
//
// A byte that neither completes a block nor ends the message leaves the input ready. The 64th
// byte of a block starts a compression (64 rounds in the shared round unit, one chaining add).
// At the end of a message the padding bytes go through the buffer one per cycle, paused by
// one or two compressions, and then eight digest words leave one per handshake.
// Reset sets the chaining words to the initial hash values; the buffer needs no clearing.
// The input is not ready while padding, compressing or sending the digest.
`default_nettype none

module sha256_message_digest (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  wire         s_axis_tuser_i,   // [0] has_byte
  input  wire         s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser_o,   // [2:0] word_index
  output logic        m_axis_tlast_o
);
  import sha256_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PAD   = 3'd1;
  localparam logic [2:0] ST_ROUND = 3'd2;
  localparam logic [2:0] ST_ADD   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [5:0]  fill_q, fill_d;
  logic [60:0] cnt_q, cnt_d;
  logic [5:0]  rnd_q, rnd_d;
  logic [2:0]  idx_q, idx_d;
  logic        pad_q, pad_d;
  logic        first_q, first_d;
  logic        len_ok_q, len_ok_d;
  logic        final_q, final_d;
  word8_t      h_q, h_d;

  sha256_ctl_t ctl;
  word_t       w;
  word8_t      v;
  logic [63:0] len_bits;
  logic        in_acc, out_acc;

  assign len_bits = {cnt_q, 3'b000};
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc  = m_axis_tvalid_o && m_axis_tready_i;

  always_comb begin
    state_d  = state_q;
    fill_d   = fill_q;
    cnt_d    = cnt_q;
    rnd_d    = rnd_q;
    idx_d    = idx_q;
    pad_d    = pad_q;
    first_d  = first_q;
    len_ok_d = len_ok_q;
    final_d  = final_q;
    h_d      = h_q;
    ctl      = '0;
    ctl.rnd  = rnd_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser_i) begin
            ctl.push_byte = 1'b1;
            ctl.byte_val  = s_axis_tdata_i;
            cnt_d         = cnt_q + 61'd1;
            fill_d        = fill_q + 6'd1;
            pad_d         = s_axis_tlast_i;
            first_d       = s_axis_tlast_i;
            if (fill_q == 6'd63) begin
              ctl.load = 1'b1;
              rnd_d    = '0;
              state_d  = ST_ROUND;
            end else if (s_axis_tlast_i) begin
              state_d = ST_PAD;
            end
          end else if (s_axis_tlast_i) begin
            pad_d   = 1'b1;
            first_d = 1'b1;
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        ctl.push_byte = 1'b1;
        fill_d        = fill_q + 6'd1;
        if (first_q) begin
          ctl.byte_val = 8'h80;
          first_d      = 1'b0;
          // The length fits in this block only if the marker byte leaves eight bytes free.
          if (fill_q <= 6'd55) begin
            len_ok_d = 1'b1;
          end
        end else if (len_ok_q && fill_q >= 6'd56) begin
          ctl.byte_val = len_bits[{~fill_q[2:0], 3'b000} +: 8];
        end else begin
          ctl.byte_val = 8'h00;
        end
        if (fill_q == 6'd63) begin
          ctl.load = 1'b1;
          rnd_d    = '0;
          state_d  = ST_ROUND;
          if (len_ok_q) begin
            final_d = 1'b1;
          end else begin
            len_ok_d = 1'b1;
          end
        end
      end
      ST_ROUND: begin
        ctl.step = 1'b1;
        rnd_d    = rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        for (int i = 0; i < 8; i++) begin
          h_d[i] = h_q[i] + v[i];
        end
        if (final_q) begin
          idx_d   = '0;
          state_d = ST_OUT;
        end else if (pad_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_acc) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            h_d      = H_INIT;
            fill_d   = '0;
            cnt_d    = '0;
            pad_d    = 1'b0;
            first_d  = 1'b0;
            len_ok_d = 1'b0;
            final_d  = 1'b0;
            state_d  = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      fill_q   <= '0;
      cnt_q    <= '0;
      rnd_q    <= '0;
      idx_q    <= '0;
      pad_q    <= 1'b0;
      first_q  <= 1'b0;
      len_ok_q <= 1'b0;
      final_q  <= 1'b0;
      h_q      <= H_INIT;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      cnt_q    <= cnt_d;
      rnd_q    <= rnd_d;
      idx_q    <= idx_d;
      pad_q    <= pad_d;
      first_q  <= first_d;
      len_ok_q <= len_ok_d;
      final_q  <= final_d;
      h_q      <= h_d;
    end
  end

  sha256_sched u_sched (
    .clk_i (clk_i),
    .ctl_i (ctl),
    .w_o   (w)
  );

  sha256_round u_round (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .w_i     (w),
    .chain_i (h_q),
    .v_o     (v)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = (state_q == ST_OUT);
  assign m_axis_tdata_o  = h_q[idx_q];
  assign m_axis_tuser_o  = idx_q;
  assign m_axis_tlast_o  = (idx_q == 3'd7);

`ifndef NO_ASSERTIONS
  // The chaining add follows the last of exactly 64 rounds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADD) |-> $past(state_q == ST_ROUND && rnd_q == 6'd63))
    else $error("chaining add without a completed round sequence");

  // The message length must not move while padding writes it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PAD) |=> $stable(cnt_q))
    else $error("bit count changed during padding");

  // After the last digest word the engine is ready for a new message.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && m_axis_tlast_o) |=> (s_axis_tready_o && fill_q == 6'd0 && !pad_q))
    else $error("engine not reinitialized after the digest");

  // A compression always starts with the block buffer full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.load |-> (fill_q == 6'd63 && ctl.push_byte))
    else $error("compression started on a partial block");
`endif

endmodule

`default_nettype wire

/* sv/sha256_sched.sv */
// Block buffer and message schedule: a 16-word shift line that takes bytes or schedule words.
`default_nettype none

module sha256_sched (
  input  wire                      clk_i,
  input  sha256_pkg::sha256_ctl_t  ctl_i,
  output sha256_pkg::word_t        w_o
);
  import sha256_pkg::*;

  // Word 0 (the oldest, w[t]) sits in the top bits; new data enters at the bottom.
  logic [511:0] win_q;
  word_t        w0, w1, w9, w14, s0, s1, w_new;

  assign w0  = win_q[511:480];
  assign w1  = win_q[479:448];
  assign w9  = win_q[223:192];
  assign w14 = win_q[63:32];

  assign s0 = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ (w1 >> 3);
  assign s1 = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]} ^ (w14 >> 10);
  assign w_new = s1 + w9 + s0 + w0;

  always_ff @(posedge clk_i) begin
    if (ctl_i.push_byte) begin
      win_q <= {win_q[503:0], ctl_i.byte_val};
    end else if (ctl_i.step) begin
      win_q <= {win_q[479:0], w_new};
    end
  end

  assign w_o = w0;

endmodule

`default_nettype wire

/* sv/sha256_round.sv */
// Compression round unit: eight working words updated by one round per cycle.
`default_nettype none

module sha256_round (
  input  wire                      clk_i,
  input  sha256_pkg::sha256_ctl_t  ctl_i,
  input  sha256_pkg::word_t        w_i,
  input  sha256_pkg::word8_t       chain_i,
  output sha256_pkg::word8_t       v_o
);
  import sha256_pkg::*;

  word8_t v_q, v_d;
  word_t  a, e, big0, big1, choose, major, x1, x2;

  assign a = v_q[0];
  assign e = v_q[4];
  assign big1   = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
  assign choose = (e & v_q[5]) ^ (~e & v_q[6]);
  assign x1     = v_q[7] + big1 + choose + ROUND_K[ctl_i.rnd] + w_i;
  assign big0   = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
  assign major  = (a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign x2     = big0 + major;

  always_comb begin
    v_d    = v_q;
    v_d[7] = v_q[6];
    v_d[6] = v_q[5];
    v_d[5] = v_q[4];
    v_d[4] = v_q[3] + x1;
    v_d[3] = v_q[2];
    v_d[2] = v_q[1];
    v_d[1] = v_q[0];
    v_d[0] = x1 + x2;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      v_q <= chain_i;
    end else if (ctl_i.step) begin
      v_q <= v_d;
    end
  end

  assign v_o = v_q;

endmodule

`default_nettype wire
